@@ src/fit_points_to_viewport_assert.svh @@
// Assertion macros for the fit_points_to_viewport checker.
// The macros use the names clk and rst of the scope they are expanded in.
`ifndef FIT_POINTS_TO_VIEWPORT_ASSERT_SVH
`define FIT_POINTS_TO_VIEWPORT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fit_points_to_viewport: assertion failed");

// Consequent checked starting in the cycle after the antecedent.
`define FPV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fit_points_to_viewport: assertion failed");

`endif

@@ src/fpv_pkg.sv @@
// Shared types and constants of the viewport fitting block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fpv_pkg;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 13;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_HEIGHT = 8'd1;

  localparam logic [CFG_DATA_BITS-1:0] TARGET_WIDTH_RESET  = 13'd2000;
  localparam logic [CFG_DATA_BITS-1:0] TARGET_HEIGHT_RESET = 13'd1950;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MX,
    ST_T_MY,
    ST_T_OUT,
    ST_F_SPAN,
    ST_F_LDX,
    ST_F_DIVX,
    ST_F_LDY,
    ST_F_DIVY,
    ST_F_SCALE,
    ST_F_MSX,
    ST_F_MLX,
    ST_F_MSY,
    ST_F_MLY,
    ST_F_OFFY
  } state_t;

  typedef enum logic [2:0] {
    MUL_PX,
    MUL_PY,
    MUL_SPAN_X,
    MUL_LOW_X,
    MUL_SPAN_Y,
    MUL_LOW_Y
  } mul_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     spans_load;
    logic     axis_y;
    logic     div_load;
    logic     div_step;
    logic     zoom_x_store;
    logic     zoom_y_store;
    logic     scale_store;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_store;
    logic     shift_x_store;
    logic     shift_y_store;
    logic     res_x_store;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

@@ src/fpv_divider.sv @@
// Restoring unsigned divider: one quotient bit per cycle while step is high.
// Stand-alone; used by the datapath for the per-axis zoom.
`timescale 1ns / 1ps

module fpv_divider #(
  parameter int NUM_BITS = 29,
  parameter int DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                step,
  input  logic [NUM_BITS-1:0] numer,
  input  logic [DEN_BITS-1:0] denom,
  output logic [NUM_BITS-1:0] quo,
  output logic                done
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [CW-1:0]       cnt;
  logic [NUM_BITS-1:0] num;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] trial;
  logic                ge;

  // The remainder stays below the divisor, so its top bit is shifted out unused.
  assign trial = {rem[DEN_BITS-2:0], num[NUM_BITS-1]};
  assign ge    = (trial >= den);
  assign done  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CW'(NUM_BITS);
    end else if (step && !done) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num <= numer;
      den <= denom;
      rem <= '0;
      quo <= '0;
    end else if (step && !done) begin
      num <= {num[NUM_BITS-2:0], 1'b0};
      rem <= ge ? (trial - den) : trial;
      quo <= {quo[NUM_BITS-2:0], ge};
    end
  end

endmodule

@@ src/fpv_datapath.sv @@
// Datapath: configuration registers, bounds, zoom and offset registers,
// the shared multiplier and the output register. Uses fpv_pkg and fpv_divider.
`timescale 1ns / 1ps

module fpv_datapath #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16,
  parameter int TDATA_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fpv_pkg::ctrl_cmd_t                  cmd,
  output fpv_pkg::ctrl_status_t               status,
  input  logic [TDATA_BITS-1:0]               in_data,
  input  logic                                in_type,
  input  logic                                cfg_valid,
  input  logic [fpv_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fpv_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         out_data
);

  import fpv_pkg::*;

  localparam int SB = 11 + FRAC_BITS;
  localparam int DB = COORD_BITS + 1;
  localparam int NB = CFG_DATA_BITS + FRAC_BITS;
  localparam int PB = DB + SB;
  localparam int SW = (COORD_BITS + 15 > 34) ? COORD_BITS + 15 : 34;

  localparam logic signed [COORD_BITS-1:0] COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [SB-1:0] SCALE_ONE = SB'(1) << FRAC_BITS;
  localparam logic [SB-1:0] SCALE_MAX = {SB{1'b1}};
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return v[31:0];
  endfunction

  logic [CFG_DATA_BITS-1:0] target_width;
  logic [CFG_DATA_BITS-1:0] target_height;

  logic signed [COORD_BITS-1:0] low_x, low_y, high_x, high_y;
  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] lcap_x, lcap_y;
  logic signed [DB-1:0]         span_x, span_y;
  logic [SB-1:0]                zoom_x, zoom_y, scale;
  logic signed [31:0]           shift_x, shift_y, res_x;
  logic [PB-1:0]                prod_mag;
  logic                         prod_neg;
  logic signed [SW-1:0]         diff;

  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic signed [DB-1:0]         mul_a;
  logic [DB-1:0]                mul_mag;
  logic signed [SW-1:0]         tv_ext, tv;
  logic signed [SW-1:0]         tgt_ext, diff_adj, half, offset;
  logic signed [SW-1:0]         shx_ext, shy_ext;
  logic signed [SW-1:0]         sum_x, sum_y;
  logic                         span_pos_x, span_pos_y;
  logic [NB-1:0]                div_numer, div_quo;
  logic [DB-1:0]                div_denom;
  logic                         div_done;
  logic [SB-1:0]                zoom_q;

  assign in_x = in_data[COORD_BITS-1:0];
  assign in_y = in_data[2*COORD_BITS-1:COORD_BITS];

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_width  <= TARGET_WIDTH_RESET;
      target_height <= TARGET_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_WIDTH:  target_width  <= cfg_data;
        REG_TARGET_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Running bounds. They are cleared once the spans have been captured.
  always_ff @(posedge clk) begin
    if (rst || cmd.spans_load) begin
      low_x  <= COORD_MAXV;
      low_y  <= COORD_MAXV;
      high_x <= COORD_MINV;
      high_y <= COORD_MINV;
    end else if (cmd.in_load && !in_type) begin
      if (in_x < low_x)  low_x  <= in_x;
      if (in_x > high_x) high_x <= in_x;
      if (in_y < low_y)  low_y  <= in_y;
      if (in_y > high_y) high_y <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      px <= in_x;
      py <= in_y;
    end
    if (cmd.spans_load) begin
      span_x <= {high_x[COORD_BITS-1], high_x} - {low_x[COORD_BITS-1], low_x};
      span_y <= {high_y[COORD_BITS-1], high_y} - {low_y[COORD_BITS-1], low_y};
      lcap_x <= low_x;
      lcap_y <= low_y;
    end
  end

  assign span_pos_x = !span_x[DB-1] && (span_x != '0);
  assign span_pos_y = !span_y[DB-1] && (span_y != '0);

  assign div_numer = cmd.axis_y ? {target_height, {FRAC_BITS{1'b0}}}
                                : {target_width, {FRAC_BITS{1'b0}}};
  assign div_denom = cmd.axis_y ? (span_y + DB'(1)) : (span_x + DB'(1));

  fpv_divider #(
    .NUM_BITS(NB),
    .DEN_BITS(DB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .load  (cmd.div_load),
    .step  (cmd.div_step),
    .numer (div_numer),
    .denom (div_denom),
    .quo   (div_quo),
    .done  (div_done)
  );

  // A quotient that does not fit the scale format saturates.
  assign zoom_q = (|div_quo[NB-1:SB]) ? SCALE_MAX : div_quo[SB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.zoom_x_store) zoom_x <= span_pos_x ? zoom_q : SCALE_ONE;
    if (cmd.zoom_y_store) zoom_y <= span_pos_y ? zoom_q : SCALE_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_ONE;
    end else if (cmd.scale_store) begin
      scale <= (zoom_x < zoom_y) ? zoom_x : zoom_y;
    end
  end

  // Shared sign-magnitude multiplier; the product is registered.
  always_comb begin
    case (cmd.mul_sel)
      MUL_PX:     mul_a = {px[COORD_BITS-1], px};
      MUL_PY:     mul_a = {py[COORD_BITS-1], py};
      MUL_SPAN_X: mul_a = span_x;
      MUL_LOW_X:  mul_a = {lcap_x[COORD_BITS-1], lcap_x};
      MUL_SPAN_Y: mul_a = span_y;
      MUL_LOW_Y:  mul_a = {lcap_y[COORD_BITS-1], lcap_y};
      default:    mul_a = '0;
    endcase
  end

  assign mul_mag = mul_a[DB-1] ? (~mul_a + 1'b1) : mul_a;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_mag <= PB'(mul_mag) * PB'(scale);
      prod_neg <= mul_a[DB-1];
    end
  end

  // Truncation toward zero: drop fraction bits of the magnitude, then restore the sign.
  assign tv_ext = SW'(prod_mag[PB-1:FRAC_BITS]);
  assign tv     = prod_neg ? -tv_ext : tv_ext;

  assign tgt_ext  = SW'(cmd.axis_y ? target_height : target_width);
  assign diff_adj = diff + SW'(diff[SW-1]);
  assign half     = diff_adj >>> 1;
  assign offset   = half - tv;

  always_ff @(posedge clk) begin
    if (cmd.diff_store) diff <= tgt_ext - tv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x <= '0;
      shift_y <= '0;
    end else begin
      if (cmd.shift_x_store) shift_x <= sat32(offset);
      if (cmd.shift_y_store) shift_y <= sat32(offset);
    end
  end

  assign shx_ext = SW'(shift_x);
  assign shy_ext = SW'(shift_y);
  assign sum_x   = tv + shx_ext;
  assign sum_y   = tv + shy_ext;

  always_ff @(posedge clk) begin
    if (cmd.res_x_store) res_x <= sat32(sum_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= {sat32(sum_y), res_x};
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ src/fpv_ctrl.sv @@
// Controller state machine: sequences the bounding, zoom and transform steps.
// Uses fpv_pkg; drives the datapath command struct.
`timescale 1ns / 1ps

module fpv_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_type,
  input  logic                  in_last,
  output logic                  in_ready,
  input  fpv_pkg::ctrl_status_t status,
  output fpv_pkg::ctrl_cmd_t    cmd
);

  import fpv_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_type) begin
            state_next = ST_T_MX;
          end else if (in_last) begin
            state_next = ST_F_SPAN;
          end
        end
      end
      ST_T_MX:    state_next = ST_T_MY;
      ST_T_MY:    state_next = ST_T_OUT;
      ST_T_OUT:   if (status.out_free) state_next = ST_IDLE;
      ST_F_SPAN:  state_next = ST_F_LDX;
      ST_F_LDX:   state_next = ST_F_DIVX;
      ST_F_DIVX:  if (status.div_done) state_next = ST_F_LDY;
      ST_F_LDY:   state_next = ST_F_DIVY;
      ST_F_DIVY:  if (status.div_done) state_next = ST_F_SCALE;
      ST_F_SCALE: state_next = ST_F_MSX;
      ST_F_MSX:   state_next = ST_F_MLX;
      ST_F_MLX:   state_next = ST_F_MSY;
      ST_F_MSY:   state_next = ST_F_MLY;
      ST_F_MLY:   state_next = ST_F_OFFY;
      ST_F_OFFY:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = accept;
      end
      ST_T_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PX;
      end
      ST_T_MY: begin
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = MUL_PY;
        cmd.res_x_store = 1'b1;
      end
      ST_T_OUT: begin
        cmd.out_load = status.out_free;
      end
      ST_F_SPAN: begin
        cmd.spans_load = 1'b1;
      end
      ST_F_LDX: begin
        cmd.div_load = 1'b1;
      end
      ST_F_DIVX: begin
        cmd.div_step     = !status.div_done;
        cmd.zoom_x_store = status.div_done;
      end
      ST_F_LDY: begin
        cmd.axis_y   = 1'b1;
        cmd.div_load = 1'b1;
      end
      ST_F_DIVY: begin
        cmd.axis_y       = 1'b1;
        cmd.div_step     = !status.div_done;
        cmd.zoom_y_store = status.div_done;
      end
      ST_F_SCALE: begin
        cmd.scale_store = 1'b1;
      end
      ST_F_MSX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SPAN_X;
      end
      ST_F_MLX: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_LOW_X;
        cmd.diff_store = 1'b1;
      end
      ST_F_MSY: begin
        cmd.mul_en        = 1'b1;
        cmd.mul_sel       = MUL_SPAN_Y;
        cmd.shift_x_store = 1'b1;
      end
      ST_F_MLY: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_LOW_Y;
        cmd.axis_y     = 1'b1;
        cmd.diff_store = 1'b1;
      end
      ST_F_OFFY: begin
        cmd.shift_y_store = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ src/fit_points_to_viewport.sv @@
// Fits a stream of 2-D points into a target_width x target_height image area.
// Bounding items (tuser 0) update the running bounds; the one with tlast set
// starts the zoom and offset computation, which uses one shared restoring
// divider that yields a quotient bit per cycle for each axis in turn. Transform
// items (tuser 1) go through the shared multiplier and take longer while the
// previous result still waits on the output register. Uses fpv_pkg, fpv_ctrl,
// fpv_datapath and fpv_divider.
`timescale 1ns / 1ps

module fit_points_to_viewport #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Fields from bit 0 up: point_x, point_y, zero fill to whole bytes.
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // Field: req_type.
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tlast,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: out_x, out_y.
  output logic [63:0]                            m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fpv_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [fpv_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  import fpv_pkg::*;

  localparam int TDATA_BITS = ((2*COORD_BITS+7)/8)*8;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  fpv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_type  (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fpv_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .TDATA_BITS (TDATA_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_type   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ src/fpv_checker.sv @@
// Port-level checker for fit_points_to_viewport, bound to the top level below.
// Depends on the macros in fit_points_to_viewport_assert.svh.
`timescale 1ns / 1ps
`include "fit_points_to_viewport_assert.svh"

module fpv_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result transaction keeps its data.
  `FPV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // A transform transaction keeps the input closed while both products are formed and the result is loaded.
  `FPV_ASSERT_NEXT(a_xform_busy, s_xfer && s_axis_tuser, !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
  // The final bounding transaction starts the zoom computation.
  `FPV_ASSERT_NEXT(a_last_busy, s_xfer && !s_axis_tuser && s_axis_tlast, !s_axis_tready ##1 !s_axis_tready)
  // A bounding transaction never raises a result.
  `FPV_ASSERT_NOW(a_bound_quiet, s_xfer && !s_axis_tuser && !m_axis_tvalid, ##1 !m_axis_tvalid)

endmodule

bind fit_points_to_viewport fpv_port_checker u_fpv_checker (.*);
